/* design/udiv_pkg.sv */
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared widths, stage types and the restoring division step for the
// pipelined 64 by 31 bit unsigned divider.
// ----------------------------------------------------------------------------
`default_nettype none

package udiv_pkg;

	localparam int DIVIDEND_W             = 64;
	localparam int DIVISOR_W              = 31;
	localparam int BITS_PER_STAGE         = 2;
	localparam int DEFAULT_DIVIDEND_WIDTH = 64;

	// Item state carried from one stage to the next
	typedef struct packed {
		logic [DIVIDEND_W-1:0] work; // remaining dividend bits on top, quotient bits below
		logic [DIVISOR_W-1:0]  rem;  // partial remainder, below den whenever den is nonzero
		logic [DIVISOR_W-1:0]  den;  // divisor
	} stage_t;

	// Finished item
	typedef struct packed {
		logic [DIVIDEND_W-1:0] quotient;
		logic [DIVISOR_W-1:0]  remainder;
	} result_t;

	// One restoring step: bring in the next dividend bit, subtract if it fits
	function automatic stage_t div_step(input stage_t s);
		logic [DIVISOR_W:0] trial;
		logic               fits;
		stage_t             r;
		trial  = {s.rem, s.work[DIVIDEND_W-1]};
		fits   = (trial >= {1'b0, s.den});
		r      = s;
		r.rem  = fits ? DIVISOR_W'(trial - {1'b0, s.den}) : trial[DIVISOR_W-1:0];
		r.work = {s.work[DIVIDEND_W-2:0], fits};
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/udiv_stage.sv */
// ----------------------------------------------------------------------------
// udiv_stage
// One pipeline stage: a fixed number of restoring steps and a register.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_stage
	import udiv_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   in_valid,
	input  wire stage_t in_data,
	output logic        out_valid,
	output stage_t      out_data
);

	stage_t next_data;
	logic   valid_s1;
	stage_t data_s1;

	// Run the steps of this stage one after the other
	always_comb begin
		next_data = in_data;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			next_data = div_step(next_data);
		end
	end

	// Control bit with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload, advance only when the pipe moves
	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= next_data;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (data_s1.den != '0)) |-> (data_s1.rem < data_s1.den))
		else $error("partial remainder not below divisor");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(valid_s1) && (!valid_s1 || $stable(data_s1))))
		else $error("stage changed while pipe held");

	a_bubble_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !in_valid) |=> !valid_s1)
		else $error("bubble did not propagate");

endmodule

`default_nettype wire

/* design/udiv_outbuf.sv */
// ----------------------------------------------------------------------------
// udiv_outbuf
// Output register with a skid register so the pipe keeps moving while a
// finished item waits; the pipe halts only when the skid is full.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_outbuf
	import udiv_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    pipe_valid,
	input  wire result_t pipe_data,
	output logic         pipe_hold,
	output logic         out_valid,
	output result_t      out_data,
	input  wire logic    out_stall
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    take;

	assign take = out_valid_q && !out_stall;

	// Control: refill output from skid first, else from the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q  <= skid_valid_q || pipe_valid;
			skid_valid_q <= 1'b0;
		end else if (pipe_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_data_q <= skid_valid_q ? skid_data_q : pipe_data;
		end else if (!skid_valid_q) begin
			skid_data_q <= pipe_data;
		end
	end

	assign pipe_hold = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item with output empty");

	a_skid_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_stall) |=> skid_valid_q)
		else $error("skid item dropped while stalled");

	a_skid_catches: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && !skid_valid_q && pipe_valid) |=> skid_valid_q)
		else $error("pipe item lost while output stalled");

endmodule

`default_nettype wire

/* design/unsigned_divider_64_by_32_unit.sv */
// An accepted item passes through the NSTAGES stage registers and then the output register.
// Throughput: one item per cycle while req_stall is low; each stage register resolves two quotient bits.
// A stalled result parks in a skid register; input stalls only when that is full.
// Reset: arst_n, asynchronous, active low, clears all valid bits; the pipe is
// empty and ready right after reset.
// ----------------------------------------------------------------------------
// unsigned_divider_64_by_32_unit
// Pipelined restoring divider: 64-bit unsigned dividend by 31-bit divisor,
// quotient and remainder, zero divisor gives zero results.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_divider_64_by_32_unit
	import udiv_pkg::*;
#(
	parameter int DIVIDEND_WIDTH = DEFAULT_DIVIDEND_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output logic [DIVIDEND_W-1:0]      quotient,
	output logic [DIVISOR_W-1:0]       remainder
);

	localparam int NSTAGES = (DIVIDEND_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	localparam int PAD     = DIVIDEND_W - NSTAGES * BITS_PER_STAGE;
	localparam logic [DIVIDEND_W-1:0] DIVIDEND_MASK =
		{DIVIDEND_W{1'b1}} >> (DIVIDEND_W - DIVIDEND_WIDTH);

	logic    pipe_valid [NSTAGES+1];
	stage_t  pipe_data  [NSTAGES+1];
	logic    pipe_hold;
	logic    en;
	result_t fin;
	result_t out_data;

	assign en = !pipe_hold;

	// Align used dividend bits to the top of the work word
	assign pipe_valid[0]     = req_valid && !pipe_hold;
	assign pipe_data[0].work = (dividend & DIVIDEND_MASK) << PAD;
	assign pipe_data[0].rem  = '0;
	assign pipe_data[0].den  = divisor;

	// Stage chain
	for (genvar k = 0; k < NSTAGES; k++) begin : g_stage
		udiv_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (pipe_valid[k]),
			.in_data   (pipe_data[k]),
			.out_valid (pipe_valid[k+1]),
			.out_data  (pipe_data[k+1])
		);
	end

	// Force zero results for a zero divisor
	always_comb begin
		if (pipe_data[NSTAGES].den == '0) begin
			fin.quotient  = '0;
			fin.remainder = '0;
		end else begin
			fin.quotient  = pipe_data[NSTAGES].work;
			fin.remainder = pipe_data[NSTAGES].rem;
		end
	end

	udiv_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.pipe_valid (pipe_valid[NSTAGES]),
		.pipe_data  (fin),
		.pipe_hold  (pipe_hold),
		.out_valid  (rsp_valid),
		.out_data   (out_data),
		.out_stall  (rsp_stall)
	);

	assign req_stall = pipe_hold;
	assign quotient  = out_data.quotient;
	assign remainder = out_data.remainder;

endmodule

`default_nettype wire
